[design/ifbs_pkg.sv]
// Package for the integer field byte serializer.
// Holds the beat structs, the format kind codes, the register map and size constants.
// Depends on nothing; every other design file imports it.
`default_nettype none

package ifbs_pkg;

    // Sizes of the encoding.
    localparam int MAX_BYTES = 10;
    localparam int CNT_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int GROUPS    = 10;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (byte address is 4 * index).
    localparam logic CFG_IDX_BE_ORDER = 1'b0;

    // Reset value of the byte order register: most significant byte first.
    localparam logic BE_ORDER_RESET = 1'b1;

    // Format kinds carried in each input beat.
    typedef enum logic [2:0] {
        KIND_BYTE        = 3'd0,
        KIND_U16         = 3'd1,
        KIND_U24         = 3'd2,
        KIND_U32         = 3'd3,
        KIND_U64         = 3'd4,
        KIND_LSB_VARINT  = 3'd5,
        KIND_U29_VARINT  = 3'd6,
        KIND_LONG_VARINT = 3'd7
    } kind_t;

    // One input beat.
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_beat_t;

    // A fully encoded item: bytes in emission order plus the byte count.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
    } enc_t;

endpackage

`default_nettype wire

[design/ifbs_encoder.sv]
// Combinational encoder: turns one registered input beat into its full byte image.
// Handles the single byte, fixed-width, and the three 7-bit varint formats.
// Depends on ifbs_pkg.
`default_nettype none

module ifbs_encoder (
    input  var ifbs_pkg::in_beat_t in_beat,
    input  var logic               big_endian,
    output var ifbs_pkg::enc_t     enc
);
    import ifbs_pkg::*;

    logic [63:0]                     w64;
    logic [GROUPS-1:0][GROUP_W-1:0]  grp;
    logic [GROUPS-1:0][GROUP_W-1:0]  wgrp;
    logic [GROUPS-2:0]               nz64;
    logic [GROUPS-2:0]               nz32;
    logic [CNT_W-1:0]                n64;
    logic [CNT_W-1:0]                n32;

    // Fixed-width field of nb bytes in the selected byte order.
    function automatic logic [MAX_BYTES-1:0][BYTE_W-1:0] fixed_bytes(
        input logic [63:0]      v,
        input logic [CNT_W-1:0] nb,
        input logic             be
    );
        logic [MAX_BYTES-1:0][BYTE_W-1:0] b;
        logic [2:0]                       idx;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            idx = be ? 3'(nb - CNT_W'(1) - CNT_W'(i)) : 3'(i);
            if (CNT_W'(i) < nb) begin
                b[i] = v[{idx, 3'b000} +: BYTE_W];
            end
        end
        return b;
    endfunction

    // Most significant group first, continuation bit on all but the final byte.
    function automatic logic [MAX_BYTES-1:0][BYTE_W-1:0] msb_bytes(
        input logic [GROUPS-1:0][GROUP_W-1:0] g,
        input logic [CNT_W-1:0]               n
    );
        logic [MAX_BYTES-1:0][BYTE_W-1:0] b;
        logic [CNT_W-1:0]                 idx;
        b = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            idx = n - CNT_W'(1) - CNT_W'(i);
            if (CNT_W'(i) < n) begin
                b[i] = {(CNT_W'(i) != n - CNT_W'(1)), g[idx]};
            end
        end
        return b;
    endfunction

    assign w64 = {32'd0, in_beat.value[31:0]};

    // 7-bit groups of the full value and of its low 32 bits.
    for (genvar k = 0; k < GROUPS; k++) begin : g_groups
        assign grp[k]  = GROUP_W'(in_beat.value >> (GROUP_W * k));
        assign wgrp[k] = GROUP_W'(w64 >> (GROUP_W * k));
    end

    // A group count is one plus the number of nonzero upper remainders.
    for (genvar k = 1; k < GROUPS; k++) begin : g_nonzero
        assign nz64[k-1] = (in_beat.value >> (GROUP_W * k)) != 64'd0;
        assign nz32[k-1] = (w64 >> (GROUP_W * k)) != 64'd0;
    end

    assign n64 = CNT_W'(1) + CNT_W'($countones(nz64));
    assign n32 = CNT_W'(1) + CNT_W'($countones(nz32));

    // Select the byte image for the format kind.
    always_comb begin
        enc.bytes = '0;
        enc.count = CNT_W'(1);
        unique case (kind_t'(in_beat.kind))
            KIND_BYTE: begin
                enc.bytes[0] = in_beat.value[7:0];
                enc.count    = CNT_W'(1);
            end
            KIND_U16: begin
                enc.bytes = fixed_bytes(in_beat.value, CNT_W'(2), big_endian);
                enc.count = CNT_W'(2);
            end
            KIND_U24: begin
                enc.bytes = fixed_bytes(in_beat.value, CNT_W'(3), big_endian);
                enc.count = CNT_W'(3);
            end
            KIND_U32: begin
                enc.bytes = fixed_bytes(in_beat.value, CNT_W'(4), big_endian);
                enc.count = CNT_W'(4);
            end
            KIND_U64: begin
                enc.bytes = fixed_bytes(in_beat.value, CNT_W'(8), big_endian);
                enc.count = CNT_W'(8);
            end
            KIND_LSB_VARINT: begin
                // Least significant group first; more follows while higher bits remain.
                for (int i = 0; i < 5; i++) begin
                    enc.bytes[i] = {(CNT_W'(i) < n32 - CNT_W'(1)), wgrp[i]};
                end
                enc.count = n32;
            end
            KIND_U29_VARINT: begin
                if (n32 >= CNT_W'(4)) begin
                    // Four bytes: three groups from bits 28..8, then a full byte.
                    enc.bytes[0] = {1'b1, in_beat.value[28:22]};
                    enc.bytes[1] = {1'b1, in_beat.value[21:15]};
                    enc.bytes[2] = {1'b1, in_beat.value[14:8]};
                    enc.bytes[3] = in_beat.value[7:0];
                    enc.count    = CNT_W'(4);
                end else begin
                    enc.bytes = msb_bytes(wgrp, n32);
                    enc.count = n32;
                end
            end
            KIND_LONG_VARINT: begin
                if (n64 == CNT_W'(MAX_BYTES)) begin
                    // Ten bytes: an empty leading group, groups from bits 63..8,
                    // then a full final byte.
                    enc.bytes[0] = 8'h80;
                    for (int i = 1; i < 9; i++) begin
                        enc.bytes[i] = {1'b1, in_beat.value[(64 - GROUP_W * i) +: GROUP_W]};
                    end
                    enc.bytes[9] = in_beat.value[7:0];
                    enc.count    = CNT_W'(MAX_BYTES);
                end else begin
                    enc.bytes = msb_bytes(grp, n64);
                    enc.count = n64;
                end
            end
            default: begin
                enc.bytes = '0;
                enc.count = CNT_W'(1);
            end
        endcase
    end

endmodule

`default_nettype wire

[design/ifbs_serializer.sv]
// Output shift register: holds one encoded item and sends it one byte per beat.
// Takes a new item on the cycle its previous last byte leaves.
// Depends on ifbs_pkg.
`default_nettype none

module ifbs_serializer (
    input  var logic                 aclk,
    input  var logic                 aresetn,
    input  var logic                 load_valid,
    input  var ifbs_pkg::enc_t       load_data,
    output var logic                 load_ready,
    output var logic                 m_valid,
    input  var logic                 m_ready,
    output var ifbs_pkg::out_beat_t  m_data
);
    import ifbs_pkg::*;

    logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_reg;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_next;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             load;

    // Free when empty, or when the final byte leaves in this cycle.
    assign load_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);
    assign load       = load_valid && load_ready;

    assign m_valid         = (cnt_reg != '0);
    assign m_data.out_byte = buf_reg[0];
    assign m_data.last     = (cnt_reg == CNT_W'(1));

    // Load a fresh item or shift one byte out per accepted beat.
    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = load_data.bytes;
            cnt_next = load_data.count;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < MAX_BYTES - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[MAX_BYTES-1] = '0;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

endmodule

`default_nettype wire

[design/integer_field_byte_serializer.sv]
// Integer field byte serializer top level: input register, byte order register,
// encoder and output serializer. Depends on ifbs_pkg, ifbs_encoder, ifbs_serializer.
//
// Each input beat carries a format kind and a 64-bit value; the block sends the
// encoding one byte per output beat, with last set on the final byte. An item
// has 1 to 10 bytes; while items keep arriving and m_ready stays high, they follow
// each other back to back, so throughput is set by the single output byte lane.
// An accepted input beat goes into the input register, then the encoder loads
// the output shift register, which presents the first byte. The byte order register
// sits at byte address 0, bit 0, and resets to most significant byte first.
`default_nettype none

module integer_field_byte_serializer (
    input  var logic                                 aclk,
    input  var logic                                 aresetn,
    // Input channel.
    input  var logic                                 s_valid,
    output var logic                                 s_ready,
    input  var ifbs_pkg::in_beat_t                   s_data,
    // Result channel.
    output var logic                                 m_valid,
    input  var logic                                 m_ready,
    output var ifbs_pkg::out_beat_t                  m_data,
    // Configuration port.
    input  var logic                                 psel,
    input  var logic                                 penable,
    input  var logic                                 pwrite,
    input  var logic [ifbs_pkg::PADDR_W-1:0]         paddr,
    input  var logic [ifbs_pkg::PDATA_W-1:0]         pwdata,
    output var logic [ifbs_pkg::PDATA_W-1:0]         prdata,
    output var logic                                 pready
);
    import ifbs_pkg::*;

    in_beat_t in_reg;
    logic     in_valid_reg;
    logic     in_valid_next;
    logic     be_order_reg;
    logic     be_order_next;
    logic     load_ready;
    logic     cfg_write;
    logic     cfg_hit;
    enc_t     enc;

    // Register file: one bit, written on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_hit   = (paddr[PADDR_W-1] == CFG_IDX_BE_ORDER);
    assign prdata    = cfg_hit ? {{(PDATA_W-1){1'b0}}, be_order_reg} : '0;

    assign be_order_next = (cfg_write && cfg_hit) ? pwdata[0] : be_order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            be_order_reg <= BE_ORDER_RESET;
        end else begin
            be_order_reg <= be_order_next;
        end
    end

    // Input register: refills in the same cycle its item moves on.
    assign s_ready = !in_valid_reg || load_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_valid_reg && load_ready) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Encoder between the input register and the output shift register.
    ifbs_encoder u_encoder (
        .in_beat    (in_reg),
        .big_endian (be_order_reg),
        .enc        (enc)
    );

    ifbs_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_data  (enc),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
